// ===== rtl/msp_pkg.sv =====
// Shared widths, limits and the token type for the max-sum partition chain.
package msp_pkg;

   localparam int VAL_W  = 32;
   localparam int SUM_W  = 48;
   localparam int CFG_W  = 5;
   localparam int PROD_W = VAL_W + 8;
   localparam int SUMX_W = SUM_W + 1;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd3;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // Partial result travelling down the row of cells
   typedef struct packed {
      logic                    valid;
      logic signed [VAL_W-1:0] seg_max;
      logic signed [SUM_W-1:0] best;
   } tok_type;

endpackage

// ===== rtl/max_sum_partition_dp_top.sv =====
// Top level of the streaming maximum-sum partition block.
//
// req_ channel carries one array element per transfer (req_tdata = value,
// req_tlast marks the final element). rsp_ channel returns one result per
// element (rsp_tdata = best partition sum of the prefix, rsp_tlast copies
// the element's last flag, so it carries the array's answer).
// csr_ channel writes the segment length limit; write it only when idle.
// A partial result walks the row of MAX_K cells, one cell per cycle, each
// cell scoring one segment length. With n = min(prefix length, limit), it
// stops at cell n-1 and the result goes into the output buffer; a new element
// is taken only after the previous element's walk has ended.
// Results sit in a two-entry output buffer: a stalled receiver stops new
// elements only once both entries are full.
// Reset (synchronous) empties the buffer, clears the element count and
// sets the limit to 3. The cell contents are not cleared: only entries
// written in the current array are read.
module max_sum_partition_dp_top #(
   parameter int MAX_K = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,  // [31:0] value
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [47:0]                   rsp_tdata,  // [47:0] best_sum
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [msp_pkg::CFG_W-1:0]     csr_data
);
   import msp_pkg::*;

   localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int CNT_W = $clog2(MAX_K + 1);
   localparam int LIM_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

   logic [CFG_W-1:0]        lim_cfg_ff, lim_cfg_in;
   logic [CNT_W-1:0]        seen_ff, seen_in;
   logic [IDX_W-1:0]        last_idx_ff, last_idx_in;
   logic                    busy_ff, busy_in;
   logic                    tlast_ff;
   tok_type                 tok0_ff;
   logic [LIM_W-1:0]        limit, avail, seen_inc;

   tok_type                 tok_chain [MAX_K+1];
   logic signed [VAL_W-1:0] rv_chain  [MAX_K+1];
   logic signed [SUM_W-1:0] pb_chain  [MAX_K+1];
   logic [MAX_K-1:0]        done_vec;
   logic                    any_done;
   logic signed [SUM_W-1:0] res_best;

   logic                    o0v_ff, o0v_in, o1v_ff, o1v_in;
   logic [SUM_W-1:0]        o0d_ff, o0d_in, o1d_ff, o1d_in;
   logic                    o0l_ff, o0l_in, o1l_ff, o1l_in;
   logic                    accept, pop;

   assign accept    = req_tvalid && req_tready;
   assign req_tready = !busy_ff && !o1v_ff;
   assign csr_ready  = 1'b1;
   assign pop        = o0v_ff && rsp_tready;

   // limit clamped to 1..MAX_K, then to the prefix length
   always_comb begin
      if (lim_cfg_ff == '0) begin
         limit = LIM_W'(1);
      end else if (LIM_W'(lim_cfg_ff) > LIM_W'(MAX_K)) begin
         limit = LIM_W'(MAX_K);
      end else begin
         limit = LIM_W'(lim_cfg_ff);
      end
      seen_inc    = LIM_W'(seen_ff) + LIM_W'(1);
      avail       = (seen_inc < limit) ? seen_inc : limit;
      last_idx_in = accept ? IDX_W'(avail - LIM_W'(1)) : last_idx_ff;
   end

   always_comb begin
      res_best = '0;
      for (int j = 0; j < MAX_K; j++) begin
         if (done_vec[j]) begin
            res_best = res_best | tok_chain[j+1].best;
         end
      end
   end
   assign any_done = |done_vec;

   always_comb begin
      lim_cfg_in = (csr_valid && csr_ready) ? csr_data : lim_cfg_ff;
      busy_in    = accept ? 1'b1 : (any_done ? 1'b0 : busy_ff);
      seen_in    = seen_ff;
      if (any_done) begin
         if (tlast_ff) begin
            seen_in = '0;
         end else if (seen_ff < CNT_W'(MAX_K)) begin
            seen_in = seen_ff + CNT_W'(1);
         end
      end
   end

   // two-entry result buffer
   always_comb begin
      o0v_in = o0v_ff;
      o0d_in = o0d_ff;
      o0l_in = o0l_ff;
      o1v_in = o1v_ff;
      o1d_in = o1d_ff;
      o1l_in = o1l_ff;
      if (pop) begin
         o0v_in = o1v_ff;
         o0d_in = o1d_ff;
         o0l_in = o1l_ff;
         o1v_in = 1'b0;
      end
      if (any_done) begin
         if (!o0v_in) begin
            o0v_in = 1'b1;
            o0d_in = res_best;
            o0l_in = tlast_ff;
         end else begin
            o1v_in = 1'b1;
            o1d_in = res_best;
            o1l_in = tlast_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_cfg_ff    <= CFG_RESET;
         seen_ff       <= '0;
         busy_ff       <= 1'b0;
         tok0_ff.valid <= 1'b0;
         o0v_ff        <= 1'b0;
         o1v_ff        <= 1'b0;
      end else begin
         lim_cfg_ff    <= lim_cfg_in;
         seen_ff       <= seen_in;
         busy_ff       <= busy_in;
         tok0_ff.valid <= accept;
         o0v_ff        <= o0v_in;
         o1v_ff        <= o1v_in;
      end
      last_idx_ff <= last_idx_in;
      o0d_ff      <= o0d_in;
      o0l_ff      <= o0l_in;
      o1d_ff      <= o1d_in;
      o1l_ff      <= o1l_in;
      if (accept) begin
         tok0_ff.seg_max <= signed'(req_tdata);
         tok0_ff.best    <= '0;
         tlast_ff        <= req_tlast;
      end
   end

   assign tok_chain[0] = tok0_ff;
   assign rv_chain[0]  = tok0_ff.seg_max;
   assign pb_chain[0]  = res_best;

   for (genvar j = 0; j < MAX_K; j++) begin : g_cell
      msp_cell #(
         .CELL_IDX (j),
         .IDX_W    (IDX_W),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (tok_chain[j]),
         .last_idx (last_idx_ff),
         .seen     (seen_ff),
         .shift_en (any_done),
         .rv_in    (rv_chain[j]),
         .pb_in    (pb_chain[j]),
         .rv_out   (rv_chain[j+1]),
         .pb_out   (pb_chain[j+1]),
         .tok_out  (tok_chain[j+1]),
         .done     (done_vec[j])
      );
   end

   assign rsp_tvalid = o0v_ff;
   assign rsp_tdata  = o0d_ff;
   assign rsp_tlast  = o0l_ff;

endmodule

// ===== rtl/msp_cell.sv =====
// One cell of the row: holds one recent element and one prefix optimum, scores one length.
module msp_cell #(
   parameter int CELL_IDX = 0,
   parameter int IDX_W    = 4,
   parameter int CNT_W    = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  msp_pkg::tok_type                tok_in,
   input  logic [IDX_W-1:0]                last_idx,
   input  logic [CNT_W-1:0]                seen,
   input  logic                            shift_en,
   input  logic signed [msp_pkg::VAL_W-1:0] rv_in,
   input  logic signed [msp_pkg::SUM_W-1:0] pb_in,
   output logic signed [msp_pkg::VAL_W-1:0] rv_out,
   output logic signed [msp_pkg::SUM_W-1:0] pb_out,
   output msp_pkg::tok_type                tok_out,
   output logic                            done
);
   import msp_pkg::*;

   logic signed [VAL_W-1:0]  rv_ff;
   logic signed [SUM_W-1:0]  pb_ff;
   tok_type                  tok_ff, tok_in_nxt;
   logic                     done_ff, done_in;
   logic signed [PROD_W-1:0] prod;
   logic signed [SUMX_W-1:0] base;
   logic signed [SUMX_W-1:0] sumx;
   logic signed [SUM_W-1:0]  cand;
   logic                     is_end;

   // segment of length CELL_IDX+1: base is the optimum just before it
   assign prod   = PROD_W'(tok_in.seg_max) * PROD_W'(CELL_IDX + 1);
   assign base   = (seen == CNT_W'(CELL_IDX)) ? '0 : SUMX_W'(pb_ff);
   assign sumx   = base + SUMX_W'(prod);
   assign is_end = (last_idx == IDX_W'(CELL_IDX));

   always_comb begin
      if (sumx[SUMX_W-1] != sumx[SUMX_W-2]) begin
         cand = sumx[SUMX_W-1] ? SUM_MIN : SUM_MAX;
      end else begin
         cand = sumx[SUM_W-1:0];
      end
   end

   always_comb begin
      tok_in_nxt.valid   = tok_in.valid && !is_end;
      tok_in_nxt.seg_max = (rv_ff > tok_in.seg_max) ? rv_ff : tok_in.seg_max;
      tok_in_nxt.best    = (CELL_IDX == 0 || cand > tok_in.best) ? cand : tok_in.best;
      done_in            = tok_in.valid && is_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_nxt.valid;
         done_ff      <= done_in;
      end
      tok_ff.seg_max <= tok_in_nxt.seg_max;
      tok_ff.best    <= tok_in_nxt.best;
      if (shift_en) begin
         rv_ff <= rv_in;
         pb_ff <= pb_in;
      end
   end

   assign rv_out  = rv_ff;
   assign pb_out  = pb_ff;
   assign tok_out = tok_ff;
   assign done    = done_ff;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the streaming maximum-sum partition block.
`timescale 1ns / 100ps

module tb;
   import msp_pkg::*;

   localparam int DEPTH  = 16;
   localparam int SETTLE = 40;   // cycles: longest walk down the row plus the output buffer

   typedef struct {
      logic signed [SUM_W-1:0] best_sum;
      logic                    is_last;
   } partition_result_type;

   // Shadow of the block: keeps its own element and prefix stores and
   // queues the result expected for every accepted element.
   class partition_scoreboard;
      logic signed [VAL_W-1:0] recent_vals[DEPTH];
      logic signed [SUM_W-1:0] prefix_opt[DEPTH];
      int                      elems_seen = 0;
      logic [CFG_W-1:0]        part_limit = CFG_RESET;
      partition_result_type    expected_sums[$];
      int                      mismatches = 0;

      function void set_limit(logic [CFG_W-1:0] lim);
         part_limit = lim;
      endfunction

      function int outstanding();
         return expected_sums.size();
      endfunction

      function void note_element(logic [VAL_W-1:0] raw, logic last);
         int                   lim;
         int                   avail;
         int                   n;
         longint               seg_max;
         longint               base;
         longint               cand;
         longint               best;
         partition_result_type r;
         if (part_limit == 0)
            lim = 1;
         else if (part_limit > DEPTH)
            lim = DEPTH;
         else
            lim = int'(part_limit);
         avail = (elems_seen + 1 > lim) ? lim : elems_seen + 1;
         seg_max = longint'($signed(raw));
         best = 0;
         for (n = 1; n <= avail; n++) begin
            if (n > 1 && longint'(recent_vals[n-2]) > seg_max)
               seg_max = longint'(recent_vals[n-2]);
            base = (n - 1 == elems_seen) ? 0 : longint'(prefix_opt[n-1]);
            cand = base + longint'(n) * seg_max;
            if (cand > longint'(SUM_MAX))
               cand = longint'(SUM_MAX);
            else if (cand < longint'(SUM_MIN))
               cand = longint'(SUM_MIN);
            if (n == 1 || cand > best)
               best = cand;
         end
         for (n = DEPTH - 1; n > 0; n--) begin
            recent_vals[n] = recent_vals[n-1];
            prefix_opt[n]  = prefix_opt[n-1];
         end
         recent_vals[0] = raw;
         prefix_opt[0]  = best[SUM_W-1:0];
         if (last)
            elems_seen = 0;
         else if (elems_seen < DEPTH)
            elems_seen++;
         r.best_sum = best[SUM_W-1:0];
         r.is_last  = last;
         expected_sums = {expected_sums, r};
      endfunction

      function void check_result(logic [SUM_W-1:0] sum, logic last);
         partition_result_type want;
         if (expected_sums.size() == 0) begin
            mismatches++;
            $error("result with nothing expected: best_sum %0d is_last %0b",
                   $signed(sum), last);
            return;
         end
         want = expected_sums.pop_front();
         if (sum !== want.best_sum) begin
            mismatches++;
            $error("best_sum: expected %0d, got %0d", want.best_sum, $signed(sum));
         end
         if (last !== want.is_last) begin
            mismatches++;
            $error("is_last: expected %0b, got %0b", want.is_last, last);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [31:0]      req_tdata  = '0;
   logic             req_tlast  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [47:0]      rsp_tdata;
   logic             rsp_tlast;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data   = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   partition_scoreboard sb = new;

   max_sum_partition_dp_top #(.MAX_K(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Receiving side: check every transfer, then draw the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tlast);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(input logic [31:0] value, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_element(value, last);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CFG_W-1:0] lim);
      csr_valid <= 1'b1;
      csr_data  <= lim;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_limit(lim);
   endtask

   function automatic logic [31:0] pick_value();
      int unsigned kind;
      kind = $urandom_range(99);
      if (kind < 10)
         return 32'h7FFF_FFFF;
      if (kind < 20)
         return 32'h8000_0000;
      if (kind < 50)
         return $urandom_range(40) - 20;
      return $urandom();
   endfunction

   // One whole array; a pause point below the length makes the sender wait
   // mid-array until every result is back.
   task automatic send_array(input int len, input int pause_at);
      int i;
      for (i = 0; i < len; i++) begin
         if (i == pause_at)
            drain();
         send_item(pick_value(), i == len - 1);
      end
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] lim, input int items, input bit pause);
      int done;
      int len;
      int kind;
      drain();
      write_limit(lim);
      done = 0;
      while (done < items) begin
         kind = $urandom_range(99);
         if (kind < 70)
            len = $urandom_range(8, 1);
         else if (kind < 90)
            len = $urandom_range(20, 9);
         else
            len = $urandom_range(40, 17);
         send_array(len, pause ? len / 2 : -1);
         pause = 1'b0;
         done += len;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 28;
      recv_idle_pct = 87;

      // reset limit of 3: single-element arrays and the field extremes
      send_item(32'h7FFF_FFFF, 1'b1);
      send_item(32'h8000_0000, 1'b1);
      send_item(32'h0000_0000, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'h0000_0001, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h0000_0005, 1'b1);
      // full depth: an array as long as the store, rising then falling
      drain();
      write_limit(5'd16);
      for (int i = 0; i < 16; i++)
         send_item((i < 9) ? i * 7 - 20 : 100 - i * 9, i == 15);

      run_phase(5'd16, 40, 1'b0);
      run_phase(5'd31, 40, 1'b0);
      run_phase(5'd2, 40, 1'b0);

      send_idle_pct = 87;
      recv_idle_pct = 28;
      run_phase(5'd0, 40, 1'b1);
      run_phase(5'd17, 40, 1'b0);
      run_phase(5'd7, 40, 1'b0);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(5'd1, 40, 1'b0);
      run_phase(5'd5, 40, 1'b0);
      run_phase(5'($urandom_range(31)), 40, 1'b0);

      drain();
      if (sb.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/msp_pkg.sv
rtl/msp_cell.sv
rtl/max_sum_partition_dp_top.sv
verif/tb.sv
